// File: hw/rtl/pef_pkg.sv
// shared widths, register codes, pipeline control bundle and saturation helper
package pef_pkg;

	// fixed field widths
	localparam int unsigned COORD_W    = 32;
	localparam int unsigned FRICTION_W = 24;
	localparam int unsigned SPEED_W    = 24;
	localparam int unsigned DT_W       = 16;
	localparam int unsigned ALPHA_W    = 8;

	// default fraction bits of the fixed-point format
	localparam int unsigned FRAC_BITS_DEF = 16;

	// configuration port
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 5;

	// pipeline depth, input register to output register
	localparam int unsigned NUM_STAGES = 6;

	// width that every pre-saturation sum is widened to
	localparam int unsigned SAT_W = 72;

	// register index codes
	typedef enum logic [2:0] {
		REG_FORCE_X     = 3'd0,
		REG_FORCE_Y     = 3'd1,
		REG_FORCE_Z     = 3'd2,
		REG_FRICTION    = 3'd3,
		REG_SPEED_SCALE = 3'd4,
		REG_TIME_STEP   = 3'd5
	} pef_reg_t;

	// per-stage load enables and the live flag where the arithmetic needs it
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic                  live_s3;
		logic                  live_s5;
	} pef_ctl_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
		logic in_range;
		in_range = (&x[SAT_W-1:COORD_W-1]) || !(|x[SAT_W-1:COORD_W-1]);
		if (in_range) begin
			return x[COORD_W-1:0];
		end else if (x[SAT_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: hw/rtl/pef_regs.sv
// configuration registers with the derived step and alpha fade
module pef_regs import pef_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [APB_ADDR_W-1:0]                      paddr,
	input  logic [APB_DATA_W-1:0]                      pwdata,
	output logic [APB_DATA_W-1:0]                      prdata,
	output logic signed [COORD_W-1:0]                  force_x,
	output logic signed [COORD_W-1:0]                  force_y,
	output logic signed [COORD_W-1:0]                  force_z,
	output logic [FRICTION_W-1:0]                      friction,
	output logic [SPEED_W+DT_W-FRAC_BITS-1:0]          step,
	output logic [SPEED_W+DT_W-FRAC_BITS+ALPHA_W-1:0]  fade
);

	localparam int unsigned STEP_W = SPEED_W + DT_W - FRAC_BITS;
	localparam int unsigned FADE_W = STEP_W + ALPHA_W;
	localparam int unsigned SDT_W  = SPEED_W + DT_W;
	localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(64'd1 << FRAC_BITS);

	logic signed [COORD_W-1:0] force_x_q;
	logic signed [COORD_W-1:0] force_y_q;
	logic signed [COORD_W-1:0] force_z_q;
	logic [FRICTION_W-1:0]     friction_q;
	logic [SPEED_W-1:0]        speed_q;
	logic [DT_W-1:0]           dt_q;
	logic [STEP_W-1:0]         step_q;
	logic [FADE_W-1:0]         fade_q;
	logic [SDT_W-1:0]          sdt_prod;
	logic [FADE_W-1:0]         fade_prod;
	logic                      wr_en;
	pef_reg_t                  reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = pef_reg_t'(paddr[APB_ADDR_W-1:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_x_q  <= '0;
			force_y_q  <= '0;
			force_z_q  <= '0;
			friction_q <= '0;
			speed_q    <= SPEED_RST;
			dt_q       <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FORCE_X:     force_x_q  <= pwdata;
				REG_FORCE_Y:     force_y_q  <= pwdata;
				REG_FORCE_Z:     force_z_q  <= pwdata;
				REG_FRICTION:    friction_q <= pwdata[FRICTION_W-1:0];
				REG_SPEED_SCALE: speed_q    <= pwdata[SPEED_W-1:0];
				REG_TIME_STEP:   dt_q       <= pwdata[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_FORCE_X:     prdata = force_x_q;
			REG_FORCE_Y:     prdata = force_y_q;
			REG_FORCE_Z:     prdata = force_z_q;
			REG_FRICTION:    prdata = APB_DATA_W'(friction_q);
			REG_SPEED_SCALE: prdata = APB_DATA_W'(speed_q);
			REG_TIME_STEP:   prdata = APB_DATA_W'(dt_q);
			default:         prdata = '0;
		endcase
	end

	// step = (speed * dt) >> FRAC_BITS, then fade = (255 * step) >> FRAC_BITS, one register each
	assign sdt_prod  = SDT_W'(speed_q) * SDT_W'(dt_q);
	assign fade_prod = ({step_q, {ALPHA_W{1'b0}}} - FADE_W'(step_q)) >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			fade_q <= '0;
		end else begin
			step_q <= sdt_prod[SDT_W-1:FRAC_BITS];
			fade_q <= fade_prod;
		end
	end

	assign force_x  = force_x_q;
	assign force_y  = force_y_q;
	assign force_z  = force_z_q;
	assign friction = friction_q;
	assign step     = step_q;
	assign fade     = fade_q;

endmodule

// File: hw/rtl/pef_axis.sv
// one axis of the velocity and position update, six register stages
module pef_axis import pef_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  pef_ctl_t                           ctl,
	input  logic signed [COORD_W-1:0]          pos_in,
	input  logic signed [COORD_W-1:0]          vel_in,
	input  logic signed [COORD_W-1:0]          force_v,
	input  logic [FRICTION_W-1:0]              friction,
	input  logic [SPEED_W+DT_W-FRAC_BITS-1:0]  step,
	output logic signed [COORD_W-1:0]          pos_out,
	output logic signed [COORD_W-1:0]          vel_out
);

	localparam int unsigned STEP_W = SPEED_W + DT_W - FRAC_BITS;
	localparam int unsigned FRIC_W = COORD_W + FRICTION_W + 1;
	localparam int unsigned PROD_W = COORD_W + STEP_W + 1;

	logic signed [COORD_W-1:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic signed [COORD_W-1:0] vel_s1, vel_s2, vel_s3, vel_s4, vel_s5, vel_s6;
	logic signed [FRIC_W-1:0]  fric_s1;
	logic signed [COORD_W-1:0] term_s2;
	logic signed [PROD_W-1:0]  tp_s3;
	logic signed [PROD_W-1:0]  pp_s5;
	logic signed [SAT_W-1:0]   fric_sh, term_sum;
	logic signed [SAT_W-1:0]   tp_sh, vel_sum;
	logic signed [SAT_W-1:0]   pp_sh, pos_sum;
	logic signed [STEP_W:0]    step_s;

	assign step_s = $signed({1'b0, step});

	// friction product
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			pos_s1  <= pos_in;
			vel_s1  <= vel_in;
			fric_s1 <= vel_in * $signed({1'b0, friction});
		end
	end

	// force minus friction
	assign fric_sh  = fric_s1 >>> FRAC_BITS;
	assign term_sum = force_v - fric_sh;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
			term_s2 <= sat32(term_sum);
		end
	end

	// acceleration times step
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
			tp_s3  <= term_s2 * step_s;
		end
	end

	// new velocity, dead particles keep theirs
	assign tp_sh   = tp_s3 >>> FRAC_BITS;
	assign vel_sum = vel_s3 + tp_sh;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			pos_s4 <= pos_s3;
			vel_s4 <= ctl.live_s3 ? sat32(vel_sum) : vel_s3;
		end
	end

	// new velocity times step
	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			pos_s5 <= pos_s4;
			vel_s5 <= vel_s4;
			pp_s5  <= vel_s4 * step_s;
		end
	end

	// new position, dead particles keep theirs
	assign pp_sh   = pp_s5 >>> FRAC_BITS;
	assign pos_sum = pos_s5 + pp_sh;

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			pos_s6 <= ctl.live_s5 ? sat32(pos_sum) : pos_s5;
			vel_s6 <= vel_s5;
		end
	end

	assign pos_out = pos_s6;
	assign vel_out = vel_s6;

endmodule

// File: hw/rtl/pef_ctrl.sv
// valid bits, stage enables and the alpha fade path
module pef_ctrl import pef_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	input  logic [ALPHA_W-1:0]                         alpha,
	input  logic                                       last_particle,
	input  logic [SPEED_W+DT_W-FRAC_BITS+ALPHA_W-1:0]  fade,
	output pef_ctl_t                                   ctl,
	output logic [ALPHA_W-1:0]                         new_alpha,
	output logic                                       expired,
	output logic                                       last_out
);

	localparam int unsigned FADE_W = SPEED_W + DT_W - FRAC_BITS + ALPHA_W;
	localparam int unsigned LAST   = NUM_STAGES - 1;

	logic [NUM_STAGES-1:0] vld_s;
	logic [NUM_STAGES-1:0] en;
	logic [ALPHA_W-1:0]    alpha_s [NUM_STAGES];
	logic [NUM_STAGES-1:0] last_s;
	logic [LAST-1:0]       live_s;
	logic                  expired_s6;
	logic                  fade_hit;

	// a stage loads when it is empty or the next one loads
	always_comb begin
		en[LAST] = !vld_s[LAST] || !out_stall;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// fade compare for the last stage
	assign fade_hit = fade >= FADE_W'(alpha_s[LAST-1]);

	// alpha, last and live flags travel with the item
	always_ff @(posedge clk) begin
		if (en[0]) begin
			alpha_s[0] <= alpha;
			last_s[0]  <= last_particle;
			live_s[0]  <= alpha != '0;
		end
		for (int k = 1; k < LAST; k++) begin
			if (en[k]) begin
				alpha_s[k] <= alpha_s[k-1];
				last_s[k]  <= last_s[k-1];
				live_s[k]  <= live_s[k-1];
			end
		end
		if (en[LAST]) begin
			last_s[LAST] <= last_s[LAST-1];
			expired_s6   <= live_s[LAST-1] && fade_hit;
			if (live_s[LAST-1] && fade_hit) begin
				alpha_s[LAST] <= '0;
			end else if (live_s[LAST-1]) begin
				alpha_s[LAST] <= alpha_s[LAST-1] - fade[ALPHA_W-1:0];
			end else begin
				alpha_s[LAST] <= alpha_s[LAST-1];
			end
		end
	end

	assign ctl.en      = en;
	assign ctl.live_s3 = live_s[2];
	assign ctl.live_s5 = live_s[4];

	assign in_stall  = !en[0];
	assign out_valid = vld_s[LAST];
	assign new_alpha = alpha_s[LAST];
	assign expired   = expired_s6;
	assign last_out  = last_s[LAST];

endmodule

// File: hw/rtl/particle_euler_update.sv
// top level of the particle euler update pipeline
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  input   | in        | in_valid / in_stall   | pos_x/y/z, vel_x/y/z, alpha, last_particle
//  output  | out       | out_valid / out_stall | new_pos_x/y/z, new_vel_x/y/z, new_alpha,
//          |           |                      | expired, last_out
//  config  | in/out    | apb psel / penable   | force_x/y/z, friction, speed_scale, time_step
//
// one item per cycle sustained while out_stall stays low; the pipeline holds
// three chained multiplies (friction, acceleration, position), each
// followed by a saturating add.
// reset clears the valid bits and returns the configuration registers to their defaults.
// a stalled output holds the last stage; earlier stages keep filling until full,
// so in_stall rises only when every stage holds an item.
module particle_euler_update import pef_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_ADDR_W-1:0]       paddr,
	input  logic [APB_DATA_W-1:0]       pwdata,
	output logic [APB_DATA_W-1:0]       prdata,
	output logic                        pready,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_W-1:0]   pos_x,
	input  logic signed [COORD_W-1:0]   pos_y,
	input  logic signed [COORD_W-1:0]   pos_z,
	input  logic signed [COORD_W-1:0]   vel_x,
	input  logic signed [COORD_W-1:0]   vel_y,
	input  logic signed [COORD_W-1:0]   vel_z,
	input  logic [ALPHA_W-1:0]          alpha,
	input  logic                        last_particle,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [COORD_W-1:0]   new_pos_x,
	output logic signed [COORD_W-1:0]   new_pos_y,
	output logic signed [COORD_W-1:0]   new_pos_z,
	output logic signed [COORD_W-1:0]   new_vel_x,
	output logic signed [COORD_W-1:0]   new_vel_y,
	output logic signed [COORD_W-1:0]   new_vel_z,
	output logic [ALPHA_W-1:0]          new_alpha,
	output logic                        expired,
	output logic                        last_out
);

	localparam int unsigned STEP_W = SPEED_W + DT_W - FRAC_BITS;
	localparam int unsigned FADE_W = STEP_W + ALPHA_W;

	logic signed [COORD_W-1:0] force_x, force_y, force_z;
	logic [FRICTION_W-1:0]     friction;
	logic [STEP_W-1:0]         step;
	logic [FADE_W-1:0]         fade;
	pef_ctl_t                  ctl;

	assign pready = 1'b1;

	// configuration registers
	pef_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.force_x  (force_x),
		.force_y  (force_y),
		.force_z  (force_z),
		.friction (friction),
		.step     (step),
		.fade     (fade)
	);

	// pipeline control and alpha path
	pef_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.alpha         (alpha),
		.last_particle (last_particle),
		.fade          (fade),
		.ctl           (ctl),
		.new_alpha     (new_alpha),
		.expired       (expired),
		.last_out      (last_out)
	);

	// one arithmetic pipeline per axis
	pef_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_x (
		.clk      (clk),
		.ctl      (ctl),
		.pos_in   (pos_x),
		.vel_in   (vel_x),
		.force_v  (force_x),
		.friction (friction),
		.step     (step),
		.pos_out  (new_pos_x),
		.vel_out  (new_vel_x)
	);

	pef_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_y (
		.clk      (clk),
		.ctl      (ctl),
		.pos_in   (pos_y),
		.vel_in   (vel_y),
		.force_v  (force_y),
		.friction (friction),
		.step     (step),
		.pos_out  (new_pos_y),
		.vel_out  (new_vel_y)
	);

	pef_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_z (
		.clk      (clk),
		.ctl      (ctl),
		.pos_in   (pos_z),
		.vel_in   (vel_z),
		.force_v  (force_z),
		.friction (friction),
		.step     (step),
		.pos_out  (new_pos_z),
		.vel_out  (new_vel_z)
	);

endmodule

// File: hw/rtl/pef_checker.sv
// port-level checks on the particle euler update, bound to the top level
module pef_checker import pef_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [COORD_W-1:0] new_pos_x,
	input logic signed [COORD_W-1:0] new_vel_x,
	input logic [ALPHA_W-1:0]        new_alpha,
	input logic                      expired,
	input logic                      last_out
);

	// a stalled result item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_pos_x) && $stable(new_vel_x)
			&& $stable(new_alpha) && $stable(expired) && $stable(last_out))
		else $error("stalled result item changed");

	// an expired particle leaves with zero alpha
	a_expired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> new_alpha == '0)
		else $error("expired item with nonzero alpha");

	// with the last stage empty the pipeline always has room
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");

	// an item taken downstream frees the input side at once
	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while output drains");

endmodule

bind particle_euler_update pef_checker u_pef_checker (.*);
